FILE: design/sass_pkg.sv
// Shared types, codes and aspect decode for the semaphore signal controller.
// No dependencies; used by the step logic, the top level and the checker.
`default_nettype none

package sass_pkg;

  localparam int ANGLE_W = 8;
  localparam int LIGHT_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  typedef logic [ANGLE_W-1:0] angle_t;
  typedef logic [LIGHT_W-1:0] light_t;

  // operations
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_HOME = 2'd2;

  // order codes
  localparam logic [2:0] ORD_STOP    = 3'd0;
  localparam logic [2:0] ORD_CLEAR   = 3'd1;
  localparam logic [2:0] ORD_WARNING = 3'd2;
  localparam logic [2:0] ORD_CAUTION = 3'd3;
  localparam logic [2:0] ORD_SHUNT   = 3'd4;

  // light masks, bit0 green, bit1 red, bit2 yellow, bit3 white
  localparam light_t LT_CLEAR   = 4'b0001;
  localparam light_t LT_STOP    = 4'b0010;
  localparam light_t LT_WARNING = 4'b0100;
  localparam light_t LT_CAUTION = 4'b0101;
  localparam light_t LT_SHUNT   = 4'b1010;
  localparam light_t LT_DARK    = 4'b0000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STOP_ANGLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_ANGLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_ANGLE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SERVO_PRESENT = 3'd7;

  typedef struct packed {
    angle_t stop_angle;
    angle_t mid_angle;
    angle_t clear_angle;
    angle_t step_increment;
    logic   blank_while_moving;
    logic   release_on_arrival;
    light_t invert_mask;
    logic   servo_present;
  } cfg_t;

  typedef struct packed {
    logic [2:0] order;
    angle_t     position;
    angle_t     target;
    light_t     lights;
    logic       attached;
  } state_t;

  typedef struct packed {
    light_t light_levels;
    light_t aspect_lights;
    angle_t arm_position;
    angle_t arm_target;
    logic   motor_attached;
    logic   motor_write;
  } result_t;

  function automatic angle_t order_target(input logic [2:0] order, input cfg_t cfg);
    case (order)
      ORD_CLEAR:               order_target = cfg.clear_angle;
      ORD_WARNING, ORD_CAUTION: order_target = cfg.mid_angle;
      default:                 order_target = cfg.stop_angle;
    endcase
  endfunction

  function automatic light_t order_lights(input logic [2:0] order);
    case (order)
      ORD_STOP:    order_lights = LT_STOP;
      ORD_CLEAR:   order_lights = LT_CLEAR;
      ORD_WARNING: order_lights = LT_WARNING;
      ORD_CAUTION: order_lights = LT_CAUTION;
      ORD_SHUNT:   order_lights = LT_SHUNT;
      default:     order_lights = LT_DARK;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: design/sass_step.sv
// Next-state and result logic for one item of the signal controller.
// Pure combinational; depends on sass_pkg.
`default_nettype none

module sass_step (
  input  wire  logic [1:0]       operation,
  input  wire  logic [2:0]       order_code,
  input  wire  sass_pkg::cfg_t   cfg,
  input  wire  sass_pkg::state_t cur,
  output       sass_pkg::state_t nxt,
  output       sass_pkg::result_t res
);
  import sass_pkg::*;

  angle_t span;
  angle_t moved;
  angle_t home_pos;
  angle_t set_tgt;
  angle_t home_tgt;
  angle_t tick_tgt;
  logic   moving_up;
  logic   wrote;

  // slew toward the stored target, snapping when within one step
  always_comb begin
    moving_up = cur.position < cur.target;
    span = moving_up ? (cur.target - cur.position) : (cur.position - cur.target);
    if (span > cfg.step_increment) begin
      moved = moving_up ? (cur.position + cfg.step_increment)
                        : (cur.position - cfg.step_increment);
    end else begin
      moved = cur.target;
    end
  end

  assign home_pos = cfg.stop_angle;
  assign set_tgt  = order_target(order_code, cfg);
  assign home_tgt = order_target(cur.order, cfg);
  assign tick_tgt = order_target(cur.order, cfg);

  always_comb begin
    nxt   = cur;
    wrote = 1'b0;
    case (operation)
      OP_SET: begin
        nxt.order  = order_code;
        nxt.target = set_tgt;
        nxt.lights = (cur.position != set_tgt && cfg.blank_while_moving)
                     ? LT_DARK : order_lights(order_code);
      end
      OP_HOME: begin
        nxt.position = home_pos;
        nxt.target   = home_tgt;
        nxt.lights   = (home_pos != home_tgt && cfg.blank_while_moving)
                       ? LT_DARK : order_lights(cur.order);
      end
      OP_TICK: begin
        if (cfg.servo_present) begin
          if (cur.position != cur.target) begin
            // target and lights are refreshed from the current registers
            nxt.position = moved;
            nxt.target   = tick_tgt;
            nxt.lights   = (moved != tick_tgt && cfg.blank_while_moving)
                           ? LT_DARK : order_lights(cur.order);
          end
          if (nxt.position == nxt.target) begin
            if (cfg.release_on_arrival) begin
              nxt.attached = 1'b0;
            end
          end else begin
            nxt.attached = 1'b1;
            wrote        = 1'b1;
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

  always_comb begin
    res.light_levels   = nxt.lights ^ cfg.invert_mask;
    res.aspect_lights  = nxt.lights;
    res.arm_position   = nxt.position;
    res.arm_target     = nxt.target;
    res.motor_attached = nxt.attached;
    res.motor_write    = wrote;
  end

endmodule

`default_nettype wire

FILE: design/semaphore_signal_aspect_servo_slew.sv
// Top level of the semaphore signal controller: config registers, state,
// output register. Depends on sass_pkg and sass_step.
//
//   port group   direction   handshake           payload
//   in_*         input       in_valid/in_ready   operation, order_code
//   out_*        output      out_valid/out_ready six result fields
//   cfg_*        input       cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item per cycle unless stalled; each item is decoded and applied to the
// state in the cycle it is accepted, and its result appears in the output
// register at the next edge. The single output register lets a new item in
// whenever the current result is being taken. Reset (synchronous) restores
// registers and state; no clearing pass. cfg_ready is always high.
`default_nettype none

module semaphore_signal_aspect_servo_slew (
  input  wire  logic                          clk,
  input  wire  logic                          rst_n,
  input  wire  logic                          in_valid,
  output       logic                          in_ready,
  input  wire  logic [1:0]                    in_operation,
  input  wire  logic [2:0]                    in_order_code,
  output       logic                          out_valid,
  input  wire  logic                          out_ready,
  output       logic [sass_pkg::LIGHT_W-1:0]  out_light_levels,
  output       logic [sass_pkg::LIGHT_W-1:0]  out_aspect_lights,
  output       logic [sass_pkg::ANGLE_W-1:0]  out_arm_position,
  output       logic [sass_pkg::ANGLE_W-1:0]  out_arm_target,
  output       logic                          out_motor_attached,
  output       logic                          out_motor_write,
  input  wire  logic                          cfg_valid,
  output       logic                          cfg_ready,
  input  wire  logic [sass_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  logic [sass_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sass_pkg::*;

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    in_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_angle         <= 8'd0;
      cfg_r.mid_angle          <= 8'd45;
      cfg_r.clear_angle        <= 8'd90;
      cfg_r.step_increment     <= 8'd1;
      cfg_r.blank_while_moving <= 1'b0;
      cfg_r.release_on_arrival <= 1'b0;
      cfg_r.invert_mask        <= LT_DARK;
      cfg_r.servo_present      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STOP_ANGLE:    cfg_r.stop_angle         <= cfg_data;
        REG_MID_ANGLE:     cfg_r.mid_angle          <= cfg_data;
        REG_CLEAR_ANGLE:   cfg_r.clear_angle        <= cfg_data;
        REG_STEP:          cfg_r.step_increment     <= cfg_data;
        REG_BLANK:         cfg_r.blank_while_moving <= cfg_data[0];
        REG_RELEASE:       cfg_r.release_on_arrival <= cfg_data[0];
        REG_INVERT:        cfg_r.invert_mask        <= cfg_data[LIGHT_W-1:0];
        REG_SERVO_PRESENT: cfg_r.servo_present      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  sass_step u_step (
    .operation  (in_operation),
    .order_code (in_order_code),
    .cfg        (cfg_r),
    .cur        (state_r),
    .nxt        (state_nxt),
    .res        (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        state_r <= state_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_light_levels   = res_r.light_levels;
  assign out_aspect_lights  = res_r.aspect_lights;
  assign out_arm_position   = res_r.arm_position;
  assign out_arm_target     = res_r.arm_target;
  assign out_motor_attached = res_r.motor_attached;
  assign out_motor_write    = res_r.motor_write;

endmodule

`default_nettype wire

FILE: design/sass_checker.sv
// Port-level checks for the semaphore signal controller and their bind.
// Depends on sass_pkg and the top level semaphore_signal_aspect_servo_slew.
`default_nettype none

module sass_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [sass_pkg::LIGHT_W-1:0]  out_light_levels,
  input wire logic [sass_pkg::ANGLE_W-1:0]  out_arm_position,
  input wire logic [sass_pkg::ANGLE_W-1:0]  out_arm_target,
  input wire logic                          out_motor_attached,
  input wire logic                          out_motor_write
);
  import sass_pkg::*;

  // a stalled result keeps its light levels, arm position and arm target
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_light_levels)
      && $stable(out_arm_position) && $stable(out_arm_target))
    else $error("stalled result changed");

  // every accepted item shows a result next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

  // a servo write only happens while the arm is still short of target
  a_write_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_motor_write |-> out_motor_attached
      && (out_arm_position != out_arm_target))
    else $error("servo written while detached or arrived");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind semaphore_signal_aspect_servo_slew sass_checker u_sass_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_light_levels   (out_light_levels),
  .out_arm_position   (out_arm_position),
  .out_arm_target     (out_arm_target),
  .out_motor_attached (out_motor_attached),
  .out_motor_write    (out_motor_write)
);

`default_nettype wire

FILE: sim/tb_semaphore_signal_aspect_servo_slew.sv
`timescale 1ns / 1ps
// Self-checking bench for the semaphore signal controller: directed items, then
// random phases, most with random valid/ready idles. Needs sass_pkg and the top level.

import sass_pkg::*;

// Tracks the signal state, predicts every result and compares accepted results.
class signal_scoreboard;
  cfg_t    cfg;
  state_t  st;
  result_t expected_q[$];
  int      faults;

  function new();
    cfg = '0;
    cfg.mid_angle      = 8'd45;
    cfg.clear_angle    = 8'd90;
    cfg.step_increment = 8'd1;
    st       = '0;
    st.order = ORD_STOP;
    faults   = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_STOP_ANGLE:    cfg.stop_angle         = data;
      REG_MID_ANGLE:     cfg.mid_angle          = data;
      REG_CLEAR_ANGLE:   cfg.clear_angle        = data;
      REG_STEP:          cfg.step_increment     = data;
      REG_BLANK:         cfg.blank_while_moving = data[0];
      REG_RELEASE:       cfg.release_on_arrival = data[0];
      REG_INVERT:        cfg.invert_mask        = data[LIGHT_W-1:0];
      REG_SERVO_PRESENT: cfg.servo_present      = data[0];
      default: ;
    endcase
  endfunction

  // target angle and lights follow the stored order
  function void aim_arm();
    case (st.order)
      ORD_CLEAR: begin
        st.target = cfg.clear_angle;
        st.lights = LT_CLEAR;
      end
      ORD_STOP: begin
        st.target = cfg.stop_angle;
        st.lights = LT_STOP;
      end
      ORD_WARNING: begin
        st.target = cfg.mid_angle;
        st.lights = LT_WARNING;
      end
      ORD_CAUTION: begin
        st.target = cfg.mid_angle;
        st.lights = LT_CAUTION;
      end
      ORD_SHUNT: begin
        st.target = cfg.stop_angle;
        st.lights = LT_SHUNT;
      end
      default: begin
        st.target = cfg.stop_angle;
        st.lights = LT_DARK;
      end
    endcase
    if (st.position != st.target && cfg.blank_while_moving)
      st.lights = LT_DARK;
  endfunction

  function void note_input(logic [1:0] op, logic [2:0] code);
    angle_t  span;
    logic    wrote;
    result_t r;
    wrote = 1'b0;
    case (op)
      OP_SET: begin
        st.order = code;
        aim_arm();
      end
      OP_HOME: begin
        st.position = cfg.stop_angle;
        st.target   = st.position;
        aim_arm();
      end
      OP_TICK: begin
        if (cfg.servo_present) begin
          if (st.position != st.target) begin
            if (st.position > st.target) begin
              span = st.position - st.target;
              if (span > cfg.step_increment) st.position = st.position - cfg.step_increment;
              else st.position = st.target;
            end else begin
              span = st.target - st.position;
              if (span > cfg.step_increment) st.position = st.position + cfg.step_increment;
              else st.position = st.target;
            end
            // target is re-read from the registers after the move
            aim_arm();
          end
          if (st.position == st.target) begin
            if (cfg.release_on_arrival) st.attached = 1'b0;
          end else begin
            st.attached = 1'b1;
            wrote = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.light_levels   = st.lights ^ cfg.invert_mask;
    r.aspect_lights  = st.lights;
    r.arm_position   = st.position;
    r.arm_target     = st.target;
    r.motor_attached = st.attached;
    r.motor_write    = wrote;
    expected_q.push_back(r);
  endfunction

  function void check_result(result_t got);
    result_t want;
    bit      bad;
    if (expected_q.size() == 0) begin
      faults++;
      if (faults <= 10)
        $display("ERROR: result with no item pending: lv=%h al=%h pos=%0d tgt=%0d att=%b wr=%b",
                 got.light_levels, got.aspect_lights, got.arm_position, got.arm_target,
                 got.motor_attached, got.motor_write);
      return;
    end
    want = expected_q.pop_front();
    bad = (got.light_levels !== want.light_levels) ||
          (got.aspect_lights !== want.aspect_lights) ||
          (got.arm_position !== want.arm_position) ||
          (got.arm_target !== want.arm_target) ||
          (got.motor_attached !== want.motor_attached) ||
          (got.motor_write !== want.motor_write);
    if (bad) begin
      faults++;
      if (faults <= 10) begin
        $display("MISMATCH %0d: want lv=%h al=%h pos=%0d tgt=%0d att=%b wr=%b", faults,
                 want.light_levels, want.aspect_lights, want.arm_position, want.arm_target,
                 want.motor_attached, want.motor_write);
        $display("              got lv=%h al=%h pos=%0d tgt=%0d att=%b wr=%b",
                 got.light_levels, got.aspect_lights, got.arm_position, got.arm_target,
                 got.motor_attached, got.motor_write);
      end
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_semaphore_signal_aspect_servo_slew;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 100;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_operation;
  logic [2:0]            in_order_code;
  logic                  out_valid;
  logic                  out_ready;
  light_t                out_light_levels;
  light_t                out_aspect_lights;
  angle_t                out_arm_position;
  angle_t                out_arm_target;
  logic                  out_motor_attached;
  logic                  out_motor_write;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  signal_scoreboard sb;
  bit no_idle;
  bit hold_req;
  int stall_cycles;

  semaphore_signal_aspect_servo_slew u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_order_code      (in_order_code),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_light_levels   (out_light_levels),
    .out_aspect_lights  (out_aspect_lights),
    .out_arm_position   (out_arm_position),
    .out_arm_target     (out_arm_target),
    .out_motor_attached (out_motor_attached),
    .out_motor_write    (out_motor_write),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic logic [7:0] pick_angle();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1:    return 8'd0;
      2, 3:    return 8'd180;
      4:       return 8'($urandom_range(181, 255));
      default: return 8'($urandom_range(0, 180));
    endcase
  endfunction

  function automatic logic [7:0] pick_step();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:          return 8'd0;
      1, 2, 3, 4: return 8'($urandom_range(1, 8));
      5, 6, 7:    return 8'($urandom_range(9, 60));
      default:    return 8'($urandom_range(61, 255));
    endcase
  endfunction

  // bench-side view of every handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (out_valid && out_ready)
        sb.check_result({out_light_levels, out_aspect_lights, out_arm_position,
                         out_arm_target, out_motor_attached, out_motor_write});
      if (in_valid && in_ready) sb.note_input(in_operation, in_order_code);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [2:0] code);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_order_code <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // stop offering items and wait for every pending result
  task automatic settle();
    in_valid <= 1'b0;
    // let the last accepted item reach the scoreboard first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_random_config();
    logic [7:0] d;
    write_reg(REG_STOP_ANGLE, pick_angle());
    write_reg(REG_MID_ANGLE, pick_angle());
    write_reg(REG_CLEAR_ANGLE, pick_angle());
    write_reg(REG_STEP, pick_step());
    write_reg(REG_BLANK, 8'($urandom_range(0, 255)));
    write_reg(REG_RELEASE, 8'($urandom_range(0, 255)));
    write_reg(REG_INVERT, 8'($urandom_range(0, 255)));
    d = 8'($urandom_range(0, 255));
    d[0] = ($urandom_range(0, 19) != 0);
    write_reg(REG_SERVO_PRESENT, d);
    cfg_valid <= 1'b0;
  endtask

  // mostly an order followed by a run of ticks toward its target
  task automatic run_items(input int count);
    int          sent;
    int unsigned r;
    int unsigned k;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(0, 19);
      if (r < 12) begin
        send_item(OP_SET, 3'($urandom_range(0, 7)));
        k = $urandom_range(1, 24);
        repeat (k) send_item(OP_TICK, 3'($urandom_range(0, 7)));
        sent += k + 1;
      end else if (r < 16) begin
        send_item(OP_TICK, 3'($urandom_range(0, 7)));
        sent++;
      end else if (r < 18) begin
        send_item(OP_HOME, 3'($urandom_range(0, 7)));
        sent++;
      end else if (r == 18) begin
        send_item(OP_SET, 3'($urandom_range(0, 7)));
        sent++;
      end else begin
        send_item(OP_UNUSED, 3'($urandom_range(0, 7)));
        sent++;
      end
    end
  endtask

  initial begin : receiver
    int unsigned wait_n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        wait_n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        wait_n = draw_gap();
      end
      if (wait_n != 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int ph;
    sb       = new();
    no_idle  = 1'b0;
    hold_req = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_operation  <= OP_TICK;
    in_order_code <= ORD_STOP;
    out_ready     <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= REG_STOP_ANGLE;
    cfg_data      <= 8'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, no arm: ticks are inert, every order code, home, unused op
    send_item(OP_TICK, ORD_STOP);
    for (int c = 0; c < 8; c++) send_item(OP_SET, 3'(c));
    send_item(OP_HOME, ORD_CLEAR);
    send_item(OP_UNUSED, ORD_SHUNT);
    send_item(OP_TICK, ORD_CAUTION);
    settle();

    // extremes: out-of-range clear angle, zero step, blanking, release, full inversion
    write_reg(REG_STOP_ANGLE, 8'd180);
    write_reg(REG_MID_ANGLE, 8'd0);
    write_reg(REG_CLEAR_ANGLE, 8'd255);
    write_reg(REG_STEP, 8'd0);
    write_reg(REG_BLANK, 8'hFF);
    write_reg(REG_RELEASE, 8'hFF);
    write_reg(REG_INVERT, 8'hFF);
    write_reg(REG_SERVO_PRESENT, 8'hFF);
    cfg_valid <= 1'b0;
    send_item(OP_SET, ORD_CLEAR);
    send_item(OP_TICK, ORD_STOP);
    send_item(OP_TICK, ORD_STOP);
    send_item(OP_SET, ORD_WARNING);
    send_item(OP_TICK, ORD_STOP);
    send_item(OP_HOME, ORD_STOP);
    send_item(OP_SET, ORD_SHUNT);
    send_item(OP_UNUSED, 3'($urandom_range(0, 7)));
    settle();

    // largest step snaps in one tick; without release the motor stays attached
    write_reg(REG_STEP, 8'd255);
    write_reg(REG_RELEASE, 8'hFE);
    cfg_valid <= 1'b0;
    send_item(OP_SET, ORD_CLEAR);
    send_item(OP_TICK, ORD_STOP);
    send_item(OP_TICK, ORD_STOP);
    send_item(OP_SET, ORD_STOP);
    send_item(OP_TICK, ORD_STOP);
    settle();

    for (ph = 0; ph < PHASES; ph++) begin
      no_idle = (ph == 2 || ph == 5);
      load_random_config();
      if (ph == 3) hold_req = 1'b1;
      run_items(PHASE_ITEMS);
      settle();
    end

    if (sb.pending() != 0)
      $display("ERROR: %0d results never arrived", sb.pending());
    if (sb.faults == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/sass_pkg.sv
design/sass_step.sv
design/semaphore_signal_aspect_servo_slew.sv
design/sass_checker.sv
sim/tb_semaphore_signal_aspect_servo_slew.sv
